/* hw/rtl/gtpid_pkg.sv */
// ----------------------------------------------------------------------------
// gtpid_pkg
// Shared types and constants of the gyro turn PID controller.
// ----------------------------------------------------------------------------
package gtpid_pkg;

  localparam int unsigned AngleW   = 24;
  localparam int unsigned TolW     = 16;
  localparam int unsigned GainW    = 24;
  localparam int unsigned CmdW     = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned ErrW     = AngleW + 1;
  localparam int unsigned SumW     = 26;
  localparam int unsigned EW       = 27;
  localparam int unsigned PTermW   = GainW + EW;
  localparam int unsigned ITermW   = GainW + SumW;
  localparam int unsigned DTermW   = GainW + ErrW + 8;
  localparam int unsigned AccW     = 60;
  localparam int unsigned SpeedW   = 34;

  // error/90 rounded: floor((128*|err| + 22) / 45) by reciprocal
  localparam logic [31:0] RecipMul   = 32'd3054198967;
  localparam int unsigned RecipShift = 37;
  localparam logic [30:0] RoundBias  = 31'd22;

  localparam logic signed [SumW+1:0] SumHi = 28'sd29491200;
  localparam logic signed [SumW+1:0] SumLo = -28'sd29491200;

  localparam logic signed [AccW-1:0] SpeedHi = 60'sd4294967296;
  localparam logic signed [AccW-1:0] SpeedLo = -60'sd4294967296;

  localparam logic [TolW-1:0] TolReset = 16'd256;

  typedef enum logic [CfgIdxW-1:0] {
    RegTarget    = 3'd0,
    RegTolerance = 3'd1,
    RegGainP     = 3'd2,
    RegGainI     = 3'd3,
    RegGainD     = 3'd4
  } cfg_reg_e;

  typedef logic signed [AngleW-1:0] angle_t;
  typedef logic signed [CmdW-1:0]   cmd_t;

  typedef struct packed {
    logic signed [AngleW-1:0] target;
    logic [TolW-1:0]          tolerance;
    logic signed [GainW-1:0]  gain_p;
    logic signed [GainW-1:0]  gain_i;
    logic signed [GainW-1:0]  gain_d;
  } cfg_t;

  typedef struct packed {
    logic                   done;
    logic signed [EW-1:0]   err_q16;
    logic signed [SumW-1:0] sum;
    logic signed [ErrW-1:0] delta;
  } track_t;

  typedef struct packed {
    logic                     done;
    logic signed [PTermW-1:0] p_term;
    logic signed [ITermW-1:0] i_term;
    logic signed [DTermW-1:0] d_term;
  } terms_t;

  typedef struct packed {
    logic                     done;
    logic signed [SpeedW-1:0] speed;
  } speed_t;

endpackage

/* hw/rtl/gtpid_in_if.sv */
// ----------------------------------------------------------------------------
// gtpid_in_if
// Heading sample channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gtpid_in_if;
  import gtpid_pkg::*;

  logic   valid;
  logic   ready;
  angle_t heading;

  modport source (output valid, output heading, input ready);
  modport sink (input valid, input heading, output ready);
endinterface

/* hw/rtl/gtpid_out_if.sv */
// ----------------------------------------------------------------------------
// gtpid_out_if
// Drive command channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gtpid_out_if;
  import gtpid_pkg::*;

  logic valid;
  logic ready;
  cmd_t left_command;
  cmd_t right_command;
  logic turn_done;

  modport source (output valid, output left_command, output right_command,
                  output turn_done, input ready);
  modport sink (input valid, input left_command, input right_command,
                input turn_done, output ready);
endinterface

/* hw/rtl/gtpid_track.sv */
// ----------------------------------------------------------------------------
// gtpid_track
// Turn tracking: origin latch, done test, scaled error and clamped integral.
// ----------------------------------------------------------------------------
module gtpid_track (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gtpid_pkg::cfg_t   cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gtpid_pkg::angle_t heading_i,
  output logic              trk_valid_o,
  input  logic              trk_ready_i,
  output gtpid_pkg::track_t trk_o
);
  import gtpid_pkg::*;

  logic                   armed_q;
  angle_t                 origin_q;
  logic signed [SumW-1:0] sum_q;
  angle_t                 last_q;
  logic                   valid_q;
  track_t                 trk_q;

  angle_t                 origin_eff;
  logic signed [SumW-1:0] sum_base;
  angle_t                 last_base;
  logic signed [ErrW-1:0] diff;
  angle_t                 turned;
  logic signed [ErrW-1:0] error;
  logic signed [ErrW-1:0] err_neg;
  logic [AngleW-1:0]      err_abs;
  logic signed [ErrW-1:0] gap;
  logic signed [ErrW-1:0] gap_neg;
  logic [AngleW-1:0]      gap_abs;
  logic signed [ErrW-1:0] turned_neg;
  logic [AngleW-1:0]      turned_abs;
  logic                   done;
  logic [30:0]            recip_in;
  logic [62:0]            recip_prod;
  logic [SumW-1:0]        quot;
  logic signed [EW-1:0]   e_q16;
  logic signed [SumW+1:0] sum_raw;
  logic signed [SumW-1:0] sum_new;
  logic signed [ErrW-1:0] delta;
  logic                   accept;

  assign in_ready_o = !valid_q || trk_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign origin_eff = armed_q ? heading_i : origin_q;
  assign sum_base   = armed_q ? '0 : sum_q;
  assign last_base  = armed_q ? '0 : last_q;

  // saturated turned angle
  assign diff = ErrW'(heading_i) - ErrW'(origin_eff);
  always_comb begin
    if (diff[ErrW-1] != diff[ErrW-2]) begin
      turned = diff[ErrW-1] ? {1'b1, {(AngleW-1){1'b0}}} : {1'b0, {(AngleW-1){1'b1}}};
    end else begin
      turned = diff[AngleW-1:0];
    end
  end

  assign error   = ErrW'(cfg_i.target) - ErrW'(turned);
  assign err_neg = -error;
  assign err_abs = error[ErrW-1] ? err_neg[AngleW-1:0] : error[AngleW-1:0];

  assign gap     = ErrW'(cfg_i.target) - ErrW'({1'b0, cfg_i.tolerance});
  assign gap_neg = -gap;
  assign gap_abs = gap[ErrW-1] ? gap_neg[AngleW-1:0] : gap[AngleW-1:0];

  assign turned_neg = -ErrW'(turned);
  assign turned_abs = turned[AngleW-1] ? turned_neg[AngleW-1:0] : turned[AngleW-1:0];

  assign done = (err_abs < AngleW'(cfg_i.tolerance)) || (turned_abs > gap_abs);

  // rounded error/90 in q16
  assign recip_in   = {err_abs, 7'b0} + RoundBias;
  assign recip_prod = recip_in * RecipMul;
  assign quot       = recip_prod[RecipShift +: SumW];
  assign e_q16      = error[ErrW-1] ? -EW'(quot) : EW'(quot);

  assign sum_raw = (SumW+2)'(sum_base) + (SumW+2)'(e_q16);
  always_comb begin
    if (sum_raw > SumHi) begin
      sum_new = SumHi[SumW-1:0];
    end else if (sum_raw < SumLo) begin
      sum_new = SumLo[SumW-1:0];
    end else begin
      sum_new = sum_raw[SumW-1:0];
    end
  end

  assign delta = ErrW'(turned) - ErrW'(last_base);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b1;
      valid_q <= 1'b0;
    end else begin
      if (accept) begin
        armed_q <= done;
      end
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (armed_q) begin
        origin_q <= heading_i;
      end
      if (done) begin
        sum_q  <= sum_base;
        last_q <= last_base;
      end else begin
        sum_q  <= sum_new;
        last_q <= turned;
      end
      trk_q.done    <= done;
      trk_q.err_q16 <= e_q16;
      trk_q.sum     <= sum_new;
      trk_q.delta   <= delta;
    end
  end

  assign trk_valid_o = valid_q;
  assign trk_o       = trk_q;
endmodule

/* hw/rtl/gtpid_gain.sv */
// ----------------------------------------------------------------------------
// gtpid_gain
// Gain products, then D minus P minus I clamped to plus or minus one.
// ----------------------------------------------------------------------------
module gtpid_gain (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gtpid_pkg::cfg_t   cfg_i,
  input  logic              trk_valid_i,
  output logic              trk_ready_o,
  input  gtpid_pkg::track_t trk_i,
  output logic              spd_valid_o,
  input  logic              spd_ready_i,
  output gtpid_pkg::speed_t spd_o
);
  import gtpid_pkg::*;

  logic   trm_valid_q;
  terms_t trm_q;
  logic   spd_valid_q;
  speed_t spd_q;
  logic   trm_ready;

  logic signed [PTermW-1:0]   p_prod;
  logic signed [ITermW-1:0]   i_prod;
  logic signed [DTermW-9:0]   d_prod;
  logic signed [AccW-1:0]     acc;
  logic signed [SpeedW-1:0]   speed;

  assign trm_ready   = !spd_valid_q || spd_ready_i;
  assign trk_ready_o = !trm_valid_q || trm_ready;

  assign p_prod = cfg_i.gain_p * trk_i.err_q16;
  assign i_prod = cfg_i.gain_i * trk_i.sum;
  assign d_prod = cfg_i.gain_d * trk_i.delta;

  assign acc = AccW'(trm_q.d_term) - AccW'(trm_q.p_term) - AccW'(trm_q.i_term);

  always_comb begin
    if (acc > SpeedHi) begin
      speed = SpeedHi[SpeedW-1:0];
    end else if (acc < SpeedLo) begin
      speed = SpeedLo[SpeedW-1:0];
    end else begin
      speed = acc[SpeedW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trm_valid_q <= 1'b0;
      spd_valid_q <= 1'b0;
    end else begin
      if (trk_ready_o) begin
        trm_valid_q <= trk_valid_i;
      end
      if (trm_ready) begin
        spd_valid_q <= trm_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (trk_valid_i && trk_ready_o) begin
      trm_q.done   <= trk_i.done;
      trm_q.p_term <= p_prod;
      trm_q.i_term <= i_prod;
      trm_q.d_term <= {d_prod, 8'b0};
    end
    if (trm_valid_q && trm_ready) begin
      spd_q.done  <= trm_q.done;
      spd_q.speed <= speed;
    end
  end

  assign spd_valid_o = spd_valid_q;
  assign spd_o       = spd_q;
endmodule

/* hw/rtl/gtpid_scale.sv */
// ----------------------------------------------------------------------------
// gtpid_scale
// Scales the clamped speed to drive commands and holds the result register.
// ----------------------------------------------------------------------------
module gtpid_scale (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              spd_valid_i,
  output logic              spd_ready_o,
  input  gtpid_pkg::speed_t spd_i,
  gtpid_out_if.source       out_ch
);
  import gtpid_pkg::*;

  logic valid_q;
  cmd_t left_q;
  cmd_t right_q;
  logic done_q;

  logic signed [SpeedW-1:0] spd_neg;
  logic [SpeedW-2:0]        spd_abs;
  logic [47:0]              scaled;
  logic [CmdW-1:0]          cmd_abs;
  cmd_t                     cmd;

  assign spd_ready_o = !valid_q || out_ch.ready;

  assign spd_neg = -spd_i.speed;
  assign spd_abs = spd_i.speed[SpeedW-1] ? spd_neg[SpeedW-2:0] : spd_i.speed[SpeedW-2:0];

  // |speed| * 32767 + 2^31, rounded back to q0
  assign scaled  = {spd_abs, 15'b0} - 48'(spd_abs) + 48'h0000_8000_0000;
  assign cmd_abs = scaled[47:32];

  always_comb begin
    if (spd_i.done) begin
      cmd = '0;
    end else if (spd_i.speed[SpeedW-1]) begin
      cmd = -cmd_abs;
    end else begin
      cmd = cmd_abs;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (spd_ready_o) begin
      valid_q <= spd_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (spd_valid_i && spd_ready_o) begin
      left_q  <= cmd;
      right_q <= -cmd;
      done_q  <= spd_i.done;
    end
  end

  assign out_ch.valid         = valid_q;
  assign out_ch.left_command  = left_q;
  assign out_ch.right_command = right_q;
  assign out_ch.turn_done     = done_q;
endmodule

/* hw/rtl/gyro_turn_pid_controller_core.sv */
// ----------------------------------------------------------------------------
// gyro_turn_pid_controller_core
// Gyro turn PID controller with integral clamp, top level.
// ----------------------------------------------------------------------------
// Takes one heading sample per cycle while not stalled and returns one command
// pair per sample. The pair is registered in the output stage after the track,
// gain-term and speed stages. The origin latch, done test, error/90 and
// integral update are combinational into the track register, which sets the
// one-sample-per-cycle rate; the gain products, the speed clamp and the command
// scaling follow in three more register stages. Each stage has its own valid
// bit, so up to three more samples enter while a finished result waits at the
// output; after that the input stalls until the result is taken. The user
// must see that registers are written through the write port only while no
// sample is in flight (not enforced); out-of-range indexes are ignored.
module gyro_turn_pid_controller_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  gtpid_in_if.sink                           in_ch,
  gtpid_out_if.source                        out_ch,
  input  logic                               cfg_we_i,
  input  logic [gtpid_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [gtpid_pkg::CfgDataW-1:0]     cfg_wdata_i
);
  import gtpid_pkg::*;

  cfg_t   cfg_q;
  logic   trk_valid;
  logic   trk_ready;
  track_t trk;
  logic   spd_valid;
  logic   spd_ready;
  speed_t spd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target    <= '0;
      cfg_q.tolerance <= TolReset;
      cfg_q.gain_p    <= '0;
      cfg_q.gain_i    <= '0;
      cfg_q.gain_d    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegTarget:    cfg_q.target    <= cfg_wdata_i;
        RegTolerance: cfg_q.tolerance <= cfg_wdata_i[TolW-1:0];
        RegGainP:     cfg_q.gain_p    <= cfg_wdata_i;
        RegGainI:     cfg_q.gain_i    <= cfg_wdata_i;
        RegGainD:     cfg_q.gain_d    <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  gtpid_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .heading_i   (in_ch.heading),
    .trk_valid_o (trk_valid),
    .trk_ready_i (trk_ready),
    .trk_o       (trk)
  );

  gtpid_gain u_gain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .trk_valid_i (trk_valid),
    .trk_ready_o (trk_ready),
    .trk_i       (trk),
    .spd_valid_o (spd_valid),
    .spd_ready_i (spd_ready),
    .spd_o       (spd)
  );

  gtpid_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .spd_valid_i (spd_valid),
    .spd_ready_o (spd_ready),
    .spd_i       (spd),
    .out_ch      (out_ch)
  );
endmodule
